// ===== rtl/mfmd_pkg.sv =====
package mfmd_pkg;

  // Default sizing
  localparam int ACC_WIDTH_DEF   = 40;
  // Q format of the reciprocal ratio; the ratio register width and its reset follow it
  localparam int RATIO_FRAC_BITS = 16;

  // Field widths
  localparam int CAN_ID_W   = 11;
  localparam int DATA_W     = 64;
  localparam int MOTOR_ID_W = 10;
  localparam int RATIO_W    = RATIO_FRAC_BITS + 1;
  localparam int CFG_DATA_W = (RATIO_W > MOTOR_ID_W) ? RATIO_W : MOTOR_ID_W;
  localparam int CFG_IDX_W  = 1;
  localparam int ANGLE_W    = 13;
  localparam int WORD_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int FAULT_W    = 3;

  // Frame layout, byte 0 in the top byte
  localparam int ANGLE_LSB   = 48;
  localparam int SPEED_LSB   = 32;
  localparam int CURRENT_LSB = 16;
  localparam int TEMP_LSB    = 8;
  localparam int STATUS_LSB  = 0;

  localparam int COUNTS_PER_TURN = 2 ** ANGLE_W;
  localparam int HALF_TURN       = COUNTS_PER_TURN / 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ID    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_RATIO = 1'b1;

  localparam logic [MOTOR_ID_W-1:0] MOTOR_ID_RST    = 10'd513;
  localparam logic [RATIO_W-1:0]    RECIP_RATIO_RST = RATIO_W'(2 ** RATIO_FRAC_BITS);

  // Status byte codes as reported by the drive
  localparam logic [BYTE_W-1:0] STAT_NONE        = 8'd0;
  localparam logic [BYTE_W-1:0] STAT_MEMORY      = 8'd1;
  localparam logic [BYTE_W-1:0] STAT_OVERVOLTAGE = 8'd2;
  localparam logic [BYTE_W-1:0] STAT_PHASE_OPEN  = 8'd3;
  localparam logic [BYTE_W-1:0] STAT_SENSOR_LOST = 8'd4;
  localparam logic [BYTE_W-1:0] STAT_OVERTEMP    = 8'd5;
  localparam logic [BYTE_W-1:0] STAT_CALIBRATION = 8'd7;
  localparam logic [BYTE_W-1:0] STAT_OVERHEAT    = 8'd8;

  // Dense fault codes
  localparam logic [FAULT_W-1:0] FAULT_NONE        = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_MEMORY      = 3'd1;
  localparam logic [FAULT_W-1:0] FAULT_OVERVOLTAGE = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_PHASE_OPEN  = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_SENSOR_LOST = 3'd4;
  localparam logic [FAULT_W-1:0] FAULT_OVERTEMP    = 3'd5;
  localparam logic [FAULT_W-1:0] FAULT_CALIBRATION = 3'd6;
  localparam logic [FAULT_W-1:0] FAULT_OVERHEAT    = 3'd7;

  typedef struct packed {
    logic                     match;
    logic [ANGLE_W-1:0]       angle;
    logic signed [WORD_W-1:0] speed;
    logic signed [WORD_W-1:0] current;
    logic [BYTE_W-1:0]        temp;
    logic [FAULT_W-1:0]       fault;
  } frame_fields_t;

endpackage

// ===== rtl/mfmd_frame_decode.sv =====
module mfmd_frame_decode
  import mfmd_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic [CAN_ID_W-1:0]         can_id_i,
  input  logic                        is_standard_i,
  input  logic [DATA_W-1:0]           frame_data_i,
  input  logic [MOTOR_ID_W-1:0]       motor_id_i,
  input  logic [ANGLE_W-1:0]          prev_angle_i,
  input  logic                        seen_first_i,
  input  logic signed [ACC_WIDTH-1:0] turn_accum_i,
  output frame_fields_t               fields_o,
  output logic signed [ACC_WIDTH-1:0] turn_o,
  output logic [ANGLE_W-1:0]          prev_angle_o,
  output logic                        seen_first_o,
  output logic signed [ACC_WIDTH-1:0] turn_accum_o
);

  localparam logic signed [ANGLE_W+1:0] HALF_S = (ANGLE_W + 2)'(HALF_TURN);
  localparam logic signed [ANGLE_W+1:0] TURN_S = (ANGLE_W + 2)'(COUNTS_PER_TURN);
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic                         match;
  logic [ANGLE_W-1:0]           angle;
  logic signed [WORD_W-1:0]     speed;
  logic [BYTE_W-1:0]            status;
  logic [FAULT_W-1:0]           fault;
  logic [ANGLE_W-1:0]           base;
  logic signed [ANGLE_W+1:0]    diff;
  logic signed [ANGLE_W+1:0]    delta;
  logic signed [ACC_WIDTH:0]    sum;
  logic signed [ACC_WIDTH-1:0]  sat;
  logic signed [ACC_WIDTH-1:0]  accum_next;

  assign match  = is_standard_i && (can_id_i == CAN_ID_W'(motor_id_i));
  assign angle  = frame_data_i[ANGLE_LSB +: ANGLE_W];
  assign speed  = frame_data_i[SPEED_LSB +: WORD_W];
  assign status = frame_data_i[STATUS_LSB +: BYTE_W];

  always_comb begin
    unique case (status)
      STAT_NONE:        fault = FAULT_NONE;
      STAT_MEMORY:      fault = FAULT_MEMORY;
      STAT_OVERVOLTAGE: fault = FAULT_OVERVOLTAGE;
      STAT_PHASE_OPEN:  fault = FAULT_PHASE_OPEN;
      STAT_SENSOR_LOST: fault = FAULT_SENSOR_LOST;
      STAT_OVERTEMP:    fault = FAULT_OVERTEMP;
      STAT_CALIBRATION: fault = FAULT_CALIBRATION;
      STAT_OVERHEAT:    fault = FAULT_OVERHEAT;
      default:          fault = FAULT_NONE;
    endcase
  end

  // first frame seeds the reference, so its delta is zero
  assign base = seen_first_i ? prev_angle_i : angle;
  assign diff = $signed({2'b00, angle}) - $signed({2'b00, base});

  always_comb begin
    delta = diff;
    if (diff < -HALF_S) begin
      delta = diff + TURN_S;
    end else if (diff > HALF_S) begin
      delta = diff - TURN_S;
    end
  end

  // saturating accumulate: overflow shows as the two top bits differing
  assign sum = (ACC_WIDTH + 1)'(turn_accum_i) + (ACC_WIDTH + 1)'(delta);

  always_comb begin
    sat = sum[ACC_WIDTH-1:0];
    if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
      sat = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end
  end

  assign accum_next   = (match && (speed == '0)) ? sat : turn_accum_i;
  assign turn_accum_o = accum_next;
  assign prev_angle_o = match ? angle : prev_angle_i;
  assign seen_first_o = seen_first_i | match;
  assign turn_o       = match ? accum_next : '0;

  always_comb begin
    fields_o = '0;
    if (match) begin
      fields_o.match   = 1'b1;
      fields_o.angle   = angle;
      fields_o.speed   = speed;
      fields_o.current = frame_data_i[CURRENT_LSB +: WORD_W];
      fields_o.temp    = frame_data_i[TEMP_LSB +: BYTE_W];
      fields_o.fault   = fault;
    end
  end

endmodule

// ===== rtl/motor_feedback_multiturn_decoder.sv =====
// Motor feedback decoder with multi-turn position tracking.
// Input channel: one received bus frame per transaction (can_id_i, is_standard_i,
//   frame_data_i), qualified by in_valid_i; in_stall_o holds the sender off.
// Output channel: one result per input transaction, qualified by out_valid_o;
//   the receiver holds it with out_stall_i. Frames for another motor still give
//   a result, with match_o low and every other field zero.
// Config: cfg_we_i writes cfg_data_i into register cfg_index_i (0 motor id,
//   1 reciprocal gear ratio). Write only while no transaction is in flight.
// Throughput: one transaction per cycle while out_stall_i stays low; four register
//   stages (input, decode and accumulate, ratio partial products, saturate and
//   output) each hand on as soon as the next one is free or moving.
// Receiver stall: the stages fill behind the output register; in_stall_o rises
//   only once the input stage holds a transaction with nowhere to go.
// Reset: asynchronous, active low. Clears all stage valids, the seen-first flag,
//   previous angle and turn accumulator, and loads the default motor id (513) and
//   a ratio of 1.0.
module motor_feedback_multiturn_decoder
  import mfmd_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config write port
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [CAN_ID_W-1:0]         can_id_i,
  input  logic                        is_standard_i,
  input  logic [DATA_W-1:0]           frame_data_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        match_o,
  output logic [ANGLE_W-1:0]          angle_counts_o,
  output logic signed [WORD_W-1:0]    speed_rpm_o,
  output logic signed [WORD_W-1:0]    current_ma_o,
  output logic [BYTE_W-1:0]           temperature_o,
  output logic [FAULT_W-1:0]          fault_code_o,
  output logic signed [ACC_WIDTH-1:0] turn_counts_o,
  output logic signed [ACC_WIDTH-1:0] shaft_counts_o
);

  // The accumulator is split in two halves so each multiply stays narrow.
  localparam int LO_W = ACC_WIDTH / 2;
  localparam int HI_W = ACC_WIDTH - LO_W;
  localparam int PW   = ACC_WIDTH + RATIO_W + 1;

  localparam logic signed [PW-1:0] SAT_MAX =
    {{(PW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_MIN =
    {{(PW - ACC_WIDTH + 1){1'b1}}, {(ACC_WIDTH - 1){1'b0}}};

  // configuration
  logic [MOTOR_ID_W-1:0] motor_id_q;
  logic [RATIO_W-1:0]    recip_ratio_q;

  // tracking state
  logic [ANGLE_W-1:0]          prev_angle_q, prev_angle_d;
  logic                        seen_first_q, seen_first_d;
  logic signed [ACC_WIDTH-1:0] turn_accum_q, turn_accum_d;

  // stage 1: input register
  logic                  s1_v_q;
  logic [CAN_ID_W-1:0]   s1_id_q;
  logic                  s1_std_q;
  logic [DATA_W-1:0]     s1_data_q;

  // stage 2: decoded frame and updated accumulator
  logic                        s2_v_q;
  frame_fields_t               s2_fields_q, s2_fields_d;
  logic signed [ACC_WIDTH-1:0] s2_turn_q, s2_turn_d;

  // stage 3: partial products of turn count by ratio
  logic                              s3_v_q;
  frame_fields_t                     s3_fields_q;
  logic signed [ACC_WIDTH-1:0]       s3_turn_q;
  logic                              s3_neg_q;
  logic [LO_W+RATIO_W-1:0]           s3_pp_lo_q, s3_pp_lo_d;
  logic signed [HI_W+RATIO_W:0]      s3_pp_hi_q, s3_pp_hi_d;

  // output register
  logic                        out_v_q;
  frame_fields_t               out_fields_q;
  logic signed [ACC_WIDTH-1:0] out_turn_q;
  logic signed [ACC_WIDTH-1:0] out_shaft_q, out_shaft_d;

  logic out_ready, s3_ready, s2_ready, s1_ready;

  logic [LO_W-1:0]          turn_lo;
  logic signed [HI_W-1:0]   turn_hi;
  logic signed [RATIO_W:0]  ratio_s;
  logic signed [PW-1:0]     prod_sum;
  logic signed [PW-1:0]     quot;

  // Ready ripples back from the output: a stage may load when it is empty or
  // its contents move on in the same cycle.
  assign out_ready  = !out_v_q || !out_stall_i;
  assign s3_ready   = !s3_v_q || out_ready;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_stall_o = !s1_ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_id_q    <= MOTOR_ID_RST;
      recip_ratio_q <= RECIP_RATIO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MOTOR_ID:    motor_id_q    <= cfg_data_i[MOTOR_ID_W-1:0];
        REG_RECIP_RATIO: recip_ratio_q <= cfg_data_i[RATIO_W-1:0];
      endcase
    end
  end

  // stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_id_q   <= can_id_i;
      s1_std_q  <= is_standard_i;
      s1_data_q <= frame_data_i;
    end
  end

  // decode and accumulate; state moves exactly when the transaction leaves stage 1
  mfmd_frame_decode #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_decode (
    .can_id_i      (s1_id_q),
    .is_standard_i (s1_std_q),
    .frame_data_i  (s1_data_q),
    .motor_id_i    (motor_id_q),
    .prev_angle_i  (prev_angle_q),
    .seen_first_i  (seen_first_q),
    .turn_accum_i  (turn_accum_q),
    .fields_o      (s2_fields_d),
    .turn_o        (s2_turn_d),
    .prev_angle_o  (prev_angle_d),
    .seen_first_o  (seen_first_d),
    .turn_accum_o  (turn_accum_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_angle_q <= '0;
      seen_first_q <= 1'b0;
      turn_accum_q <= '0;
      s2_v_q       <= 1'b0;
    end else begin
      if (s1_v_q && s2_ready) begin
        prev_angle_q <= prev_angle_d;
        seen_first_q <= seen_first_d;
        turn_accum_q <= turn_accum_d;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_ready) begin
      s2_fields_q <= s2_fields_d;
      s2_turn_q   <= s2_turn_d;
    end
  end

  // stage 3: signed high half times ratio, unsigned low half times ratio
  assign turn_lo    = s2_turn_q[LO_W-1:0];
  assign turn_hi    = s2_turn_q[ACC_WIDTH-1:LO_W];
  assign ratio_s    = $signed({1'b0, recip_ratio_q});
  assign s3_pp_lo_d = turn_lo * recip_ratio_q;
  assign s3_pp_hi_d = turn_hi * ratio_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_ready) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q && s3_ready) begin
      s3_fields_q <= s2_fields_q;
      s3_turn_q   <= s2_turn_q;
      s3_neg_q    <= s2_turn_q[ACC_WIDTH-1];
      s3_pp_lo_q  <= s3_pp_lo_d;
      s3_pp_hi_q  <= s3_pp_hi_d;
    end
  end

  // Recombine, round toward zero (bias negatives by one ulp less than a unit
  // before the arithmetic shift) and clamp to the accumulator range.
  assign prod_sum = (PW'(s3_pp_hi_q) <<< LO_W)
                  + $signed(PW'(s3_pp_lo_q))
                  + $signed(PW'({RATIO_FRAC_BITS{s3_neg_q}}));
  assign quot     = prod_sum >>> RATIO_FRAC_BITS;

  always_comb begin
    out_shaft_d = quot[ACC_WIDTH-1:0];
    if (quot > SAT_MAX) begin
      out_shaft_d = SAT_MAX[ACC_WIDTH-1:0];
    end else if (quot < SAT_MIN) begin
      out_shaft_d = SAT_MIN[ACC_WIDTH-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_v_q && out_ready) begin
      out_fields_q <= s3_fields_q;
      out_turn_q   <= s3_turn_q;
      out_shaft_q  <= out_shaft_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign match_o        = out_fields_q.match;
  assign angle_counts_o = out_fields_q.angle;
  assign speed_rpm_o    = out_fields_q.speed;
  assign current_ma_o   = out_fields_q.current;
  assign temperature_o  = out_fields_q.temp;
  assign fault_code_o   = out_fields_q.fault;
  assign turn_counts_o  = out_turn_q;
  assign shaft_counts_o = out_shaft_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb
  import mfmd_pkg::*;
;

  localparam int ACC_W       = ACC_WIDTH_DEF;
  localparam int FRAC_BITS   = RATIO_FRAC_BITS;
  localparam int QUIET_LIMIT = 2000;  // cycles with no transaction before giving up
  localparam int MAX_REPORTS = 200;   // keeps the log short on a badly broken build
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 250;

  // status values the drive never defines, all of which map to no fault
  localparam logic [BYTE_W-1:0] STAT_RESERVED      = 8'd6;
  localparam logic [BYTE_W-1:0] STAT_FIRST_UNKNOWN = 8'd9;
  localparam logic [BYTE_W-1:0] STAT_TOP           = 8'hFF;

  // register settings per random phase; the first motor id word carries junk above bit 9
  localparam logic [CFG_DATA_W-1:0] PHASE_ID [PHASES] =
    '{17'h1FE0B, 17'd517, 17'd513, 17'd520, 17'd519, 17'd523};
  localparam logic [CFG_DATA_W-1:0] PHASE_RATIO [PHASES] =
    '{17'd0, 17'd32768, 17'd131071, 17'd1, 17'd43691, 17'd65536};
  localparam int PHASE_DRIFT [PHASES] = '{1, -1, 1, -1, 1, -1};

  typedef struct packed {
    logic                     match;
    logic [ANGLE_W-1:0]       angle;
    logic signed [WORD_W-1:0] speed;
    logic signed [WORD_W-1:0] current;
    logic [BYTE_W-1:0]        temp;
    logic [FAULT_W-1:0]       fault;
    logic signed [ACC_W-1:0]  turns;
    logic signed [ACC_W-1:0]  shaft;
  } decoded_t;

  // one stimulus row; when typed is set the expected result is taken from want
  typedef struct packed {
    logic [CAN_ID_W-1:0] id;
    logic                is_std;
    logic [DATA_W-1:0]   data;
    logic                typed;
    decoded_t            want;
  } frame_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [CAN_ID_W-1:0]   can_id_i;
  logic                  is_standard_i;
  logic [DATA_W-1:0]     frame_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  match_o;
  logic [ANGLE_W-1:0]    angle_counts_o;
  logic signed [WORD_W-1:0] speed_rpm_o;
  logic signed [WORD_W-1:0] current_ma_o;
  logic [BYTE_W-1:0]     temperature_o;
  logic [FAULT_W-1:0]    fault_code_o;
  logic signed [ACC_W-1:0] turn_counts_o;
  logic signed [ACC_W-1:0] shaft_counts_o;

  // side-band of the row on the input channel, read when the transaction is taken
  logic     row_typed;
  decoded_t row_want;

  // predictor state: its own copy of the registers and of the tracking state
  logic [MOTOR_ID_W-1:0] motor_id_q;
  logic [RATIO_W-1:0]    ratio_q;
  logic [ANGLE_W-1:0]    prev_angle_q;
  logic                  seen_first_q;
  longint                turn_total_q;

  decoded_t   pending_results[$];
  frame_row_t directed_rows[$];

  int  fail_count;
  int  frames_sent;
  int  frames_for_motor;
  int  results_checked;
  int  quiet_cycles;
  bit  idle_on;

  motor_feedback_multiturn_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .can_id_i       (can_id_i),
    .is_standard_i  (is_standard_i),
    .frame_data_i   (frame_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_o        (match_o),
    .angle_counts_o (angle_counts_o),
    .speed_rpm_o    (speed_rpm_o),
    .current_ma_o   (current_ma_o),
    .temperature_o  (temperature_o),
    .fault_code_o   (fault_code_o),
    .turn_counts_o  (turn_counts_o),
    .shaft_counts_o (shaft_counts_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // status byte to dense fault code; anything undefined reads as healthy
  function automatic logic [FAULT_W-1:0] fault_of(logic [BYTE_W-1:0] status);
    case (status)
      STAT_NONE:        return FAULT_NONE;
      STAT_MEMORY:      return FAULT_MEMORY;
      STAT_OVERVOLTAGE: return FAULT_OVERVOLTAGE;
      STAT_PHASE_OPEN:  return FAULT_PHASE_OPEN;
      STAT_SENSOR_LOST: return FAULT_SENSOR_LOST;
      STAT_OVERTEMP:    return FAULT_OVERTEMP;
      STAT_CALIBRATION: return FAULT_CALIBRATION;
      STAT_OVERHEAT:    return FAULT_OVERHEAT;
      default:          return FAULT_NONE;
    endcase
  endfunction

  // turns * ratio / 2^FRAC_BITS, truncated toward zero and clamped to ACC_W signed
  function automatic logic signed [ACC_W-1:0] shaft_of(longint turns,
                                                       logic [RATIO_W-1:0] ratio);
    bit              neg;
    longint unsigned mag;
    longint unsigned quot;
    longint unsigned ceiling;
    longint          res;
    neg     = turns < 0;
    mag     = neg ? -turns : turns;
    ceiling = neg ? (64'd1 << (ACC_W - 1)) : (64'd1 << (ACC_W - 1)) - 64'd1;
    quot    = (mag * 64'(ratio)) >> FRAC_BITS;
    if (quot > ceiling) quot = ceiling;
    res = neg ? -longint'(quot) : longint'(quot);
    return res[ACC_W-1:0];
  endfunction

  // decodes one frame and advances the predictor state
  function automatic decoded_t decode_frame(logic [CAN_ID_W-1:0] id, logic is_std,
                                            logic [DATA_W-1:0] d);
    decoded_t res;
    int       now_ang;
    int       old_ang;
    int       delta;
    longint   top;
    res = '0;
    if (!is_std || id != {1'b0, motor_id_q}) return res;
    top = (64'sd1 <<< (ACC_W - 1)) - 1;
    res.match   = 1'b1;
    res.angle   = d[ANGLE_LSB +: ANGLE_W];
    res.speed   = d[SPEED_LSB +: WORD_W];
    res.current = d[CURRENT_LSB +: WORD_W];
    res.temp    = d[TEMP_LSB +: BYTE_W];
    res.fault   = fault_of(d[STATUS_LSB +: BYTE_W]);
    // the very first frame only seeds the previous angle
    if (!seen_first_q) begin
      prev_angle_q = res.angle;
      seen_first_q = 1'b1;
    end
    // turns are only counted while the rotor reports standstill
    if (res.speed == 0) begin
      now_ang = int'(res.angle);
      old_ang = int'(prev_angle_q);
      delta   = now_ang - old_ang;
      if (delta < -HALF_TURN) delta += COUNTS_PER_TURN;
      else if (delta > HALF_TURN) delta -= COUNTS_PER_TURN;
      if (delta > 0 && turn_total_q > top - delta) turn_total_q = top;
      else if (delta < 0 && turn_total_q < -top - 1 - delta) turn_total_q = -top - 1;
      else turn_total_q += delta;
    end
    prev_angle_q = res.angle;
    res.turns = turn_total_q[ACC_W-1:0];
    res.shaft = shaft_of(turn_total_q, ratio_q);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [DATA_W-1:0] pack_frame(logic [WORD_W-1:0] ang,
      logic [WORD_W-1:0] spd, logic [WORD_W-1:0] cur, logic [BYTE_W-1:0] temp,
      logic [BYTE_W-1:0] status);
    return {ang, spd, cur, temp, status};
  endfunction

  // result of an accepted frame while the turn count still sits at zero
  function automatic decoded_t accepted(logic [ANGLE_W-1:0] ang, logic [WORD_W-1:0] spd,
      logic [WORD_W-1:0] cur, logic [BYTE_W-1:0] temp, logic [FAULT_W-1:0] fault);
    decoded_t res;
    res         = '0;
    res.match   = 1'b1;
    res.angle   = ang;
    res.speed   = spd;
    res.current = cur;
    res.temp    = temp;
    res.fault   = fault;
    return res;
  endfunction

  function automatic frame_row_t make_row(logic [CAN_ID_W-1:0] id, logic is_std,
      logic [DATA_W-1:0] d, logic typed, decoded_t want);
    frame_row_t r;
    r.id     = id;
    r.is_std = is_std;
    r.data   = d;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  // mostly frames for the configured motor walking the rotor in one direction,
  // with half-turn jumps, standstill, and a share of foreign or malformed frames
  function automatic frame_row_t random_frame(int drift);
    frame_row_t        r;
    int                pick;
    int                mag;
    int                step;
    int                next_ang;
    logic [2:0]        junk;
    logic [WORD_W-1:0] spd;
    logic [BYTE_W-1:0] status;
    r        = '0;
    r.id     = {1'b0, motor_id_q};
    r.is_std = 1'b1;
    r.data   = {$urandom, $urandom};
    pick     = $urandom_range(0, 99);
    if (pick < 15) begin
      r.id     = CAN_ID_W'($urandom_range(0, 2047));
      r.is_std = 1'($urandom_range(0, 1));
      return r;
    end
    if (pick < 22) begin
      if ($urandom_range(0, 1)) r.is_std = 1'b0;
      else r.id = r.id ^ (11'd1 << $urandom_range(0, CAN_ID_W - 1));
      return r;
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      mag  = $urandom_range(0, 400);
      step = drift * mag + $urandom_range(0, 200) - 100;
    end else if (pick < 7) begin
      mag  = 4090 + $urandom_range(0, 12);
      step = $urandom_range(0, 1) ? mag : -mag;
    end else if (pick < 8) begin
      step = 0;
    end else begin
      step = $urandom_range(0, COUNTS_PER_TURN - 1);
    end
    next_ang = int'(prev_angle_q) + step;
    junk     = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b000;
    spd      = ($urandom_range(0, 99) < 65) ? '0 : WORD_W'($urandom);
    status   = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom)
                                           : BYTE_W'($urandom_range(0, 9));
    r.data = pack_frame({junk, next_ang[ANGLE_W-1:0]}, spd, WORD_W'($urandom),
                        BYTE_W'($urandom), status);
    return r;
  endfunction

  task automatic build_directed();
    decoded_t none;
    none = '0;
    // rejected: extended id, wrong id, id alias above bit 9, extremes
    directed_rows.push_back(make_row(11'd513, 1'b0, '1, 1'b1, none));
    directed_rows.push_back(make_row(11'd514, 1'b1, '0, 1'b1, none));
    directed_rows.push_back(make_row(11'd1537, 1'b1,
      pack_frame(16'h0100, 16'h0000, 16'h0001, 8'h20, STAT_NONE), 1'b1, none));
    directed_rows.push_back(make_row(11'd2047, 1'b1, '1, 1'b1, none));
    directed_rows.push_back(make_row(11'd0, 1'b0, '0, 1'b1, none));
    // first accepted frame at standstill: seeds the previous angle, no turn counted
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'hFFFF, 16'h0000, 16'h7FFF, 8'hFF, STAT_NONE), 1'b1,
      accepted(13'h1FFF, 16'h0000, 16'h7FFF, 8'hFF, FAULT_NONE)));
    // every status code while turning, so the count stays at zero
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'h0000, 16'h8000, 16'h8000, 8'h00, STAT_MEMORY), 1'b1,
      accepted(13'h0000, 16'h8000, 16'h8000, 8'h00, FAULT_MEMORY)));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'h2000, 16'h7FFF, 16'h0001, 8'h19, STAT_OVERVOLTAGE), 1'b1,
      accepted(13'h0000, 16'h7FFF, 16'h0001, 8'h19, FAULT_OVERVOLTAGE)));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'h1000, 16'hFFFF, 16'hFFFF, 8'h80, STAT_PHASE_OPEN), 1'b1,
      accepted(13'h1000, 16'hFFFF, 16'hFFFF, 8'h80, FAULT_PHASE_OPEN)));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'h0123, 16'h0001, 16'h1234, 8'h30, STAT_SENSOR_LOST), 1'b1,
      accepted(13'h0123, 16'h0001, 16'h1234, 8'h30, FAULT_SENSOR_LOST)));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'h1FFF, 16'h0100, 16'h0000, 8'h7F, STAT_OVERTEMP), 1'b1,
      accepted(13'h1FFF, 16'h0100, 16'h0000, 8'h7F, FAULT_OVERTEMP)));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'h0800, 16'h0010, 16'h00FF, 8'h40, STAT_CALIBRATION), 1'b1,
      accepted(13'h0800, 16'h0010, 16'h00FF, 8'h40, FAULT_CALIBRATION)));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'h0FFF, 16'hF000, 16'h8001, 8'hFE, STAT_OVERHEAT), 1'b1,
      accepted(13'h0FFF, 16'hF000, 16'h8001, 8'hFE, FAULT_OVERHEAT)));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'h0400, 16'h0002, 16'h0002, 8'h01, STAT_RESERVED), 1'b1,
      accepted(13'h0400, 16'h0002, 16'h0002, 8'h01, FAULT_NONE)));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'h0401, 16'h0004, 16'h0003, 8'h02, STAT_FIRST_UNKNOWN), 1'b1,
      accepted(13'h0401, 16'h0004, 16'h0003, 8'h02, FAULT_NONE)));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'hE005, 16'h0003, 16'h7000, 8'h55, STAT_TOP), 1'b1,
      accepted(13'h0005, 16'h0003, 16'h7000, 8'h55, FAULT_NONE)));
    // standstill: no move, wraps both ways, exactly half a turn both ways, just past it
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'd5, 16'h0000, 16'h0010, 8'h20, STAT_NONE), 1'b0, none));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'd8190, 16'h0000, 16'h0010, 8'h20, STAT_NONE), 1'b0, none));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'd3, 16'h0000, 16'h0010, 8'h20, STAT_NONE), 1'b0, none));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'd4099, 16'h0000, 16'h0010, 8'h20, STAT_NONE), 1'b0, none));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'd3, 16'h0000, 16'h0010, 8'h20, STAT_NONE), 1'b0, none));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'd4100, 16'h0000, 16'h0010, 8'h20, STAT_NONE), 1'b0, none));
    // moving: angle tracked but no turn counted, then standstill again
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'd100, 16'h8000, 16'h0010, 8'h20, STAT_NONE), 1'b0, none));
    directed_rows.push_back(make_row(11'd513, 1'b1,
      pack_frame(16'd200, 16'h0000, 16'h0010, 8'h20, STAT_NONE), 1'b0, none));
    // a foreign frame mid-sequence must leave the tracking alone
    directed_rows.push_back(make_row(11'd513, 1'b0,
      pack_frame(16'd7000, 16'h0000, 16'h0010, 8'h20, STAT_NONE), 1'b1, none));
  endtask

  // ---------------------------------------------------------------------------
  // Channel drivers, all changes on the falling edge
  // ---------------------------------------------------------------------------

  // one input transaction; returns at the falling edge after it was taken
  task automatic send_frame(frame_row_t r);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    can_id_i      <= r.id;
    is_standard_i <= r.is_std;
    frame_data_i  <= r.data;
    row_typed     <= r.typed;
    row_want      <= r.want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    frames_sent++;
    @(negedge clk_i);
  endtask

  // every frame gives a result, so an empty queue means the pipe is empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MOTOR_ID:    motor_id_q = val[MOTOR_ID_W-1:0];
      REG_RECIP_RATIO: ratio_q    = val[RATIO_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // receiver back-pressure in bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and checker, sampling on the rising edge
  // ---------------------------------------------------------------------------

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t tb: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    decoded_t predicted;
    decoded_t got;
    decoded_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (in_valid_i && !in_stall_o) begin
        quiet_cycles = 0;
        predicted = decode_frame(can_id_i, is_standard_i, frame_data_i);
        if (predicted.match) frames_for_motor++;
        pending_results.push_back(row_typed ? row_want : predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        quiet_cycles = 0;
        got = {match_o, angle_counts_o, speed_rpm_o, current_ma_o, temperature_o,
               fault_code_o, turn_counts_o, shaft_counts_o};
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t tb: result transaction with nothing expected, actual 0x%0h",
                   $time, got);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          check_field("match", want.match, got.match);
          check_field("angle_counts", want.angle, got.angle);
          check_field("speed_rpm", want.speed, got.speed);
          check_field("current_ma", want.current, got.current);
          check_field("temperature", want.temp, got.temp);
          check_field("fault_code", want.fault, got.fault);
          check_field("turn_counts", want.turns, got.turns);
          check_field("shaft_counts", want.shaft, got.shaft);
        end
      end
      if (cfg_we_i) quiet_cycles = 0;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t tb: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_MOTOR_ID;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    can_id_i      = '0;
    is_standard_i = 1'b0;
    frame_data_i  = '0;
    row_typed     = 1'b0;
    row_want      = '0;
    motor_id_q    = MOTOR_ID_RST;
    ratio_q       = RECIP_RATIO_RST;
    prev_angle_q  = '0;
    seen_first_q  = 1'b0;
    turn_total_q  = 0;
    fail_count    = 0;
    frames_sent   = 0;
    frames_for_motor = 0;
    results_checked  = 0;
    quiet_cycles  = 0;
    idle_on       = 1'b1;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows run on the reset register values
    build_directed();
    foreach (directed_rows[i]) send_frame(directed_rows[i]);
    drain();

    // random phases, each on fresh register values; the last one runs flat out
    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p != PHASES - 1);
      write_reg(REG_MOTOR_ID, PHASE_ID[p]);
      write_reg(REG_RECIP_RATIO, PHASE_RATIO[p]);
      repeat (PHASE_ITEMS) send_frame(random_frame(PHASE_DRIFT[p]));
      drain();
    end

    repeat (8) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0t tb: %0d results never arrived", $time, pending_results.size());
    end

    $display("tb: %0d frames over %0d register settings, %0d for the motor, %0d checked",
             frames_sent, PHASES + 1, frames_for_motor, results_checked);
    $display("tb: final turn count %0d, %0d mismatches", turn_total_q, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
